// ----- rtl/bcc_pkg.sv -----
// Package for the button click classifier: request/result structs,
// register indexes, reset values and event codes. No dependencies.
package bcc_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned STEP_W         = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP    = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0]  DOUBLE_GAP_RST   = 16'd400;
  localparam logic [CFG_W-1:0]  LONG_TIME_RST    = 16'd1000;
  localparam logic [CFG_W-1:0]  MIN_TIME_RST     = 16'd50;
  localparam logic [CFG_W-1:0]  STUCK_TIME_RST   = 16'd1500;
  localparam logic [CFG_W-1:0]  CONFIRM_TIME_RST = 16'd3000;
  localparam logic [STEP_W-1:0] SCAN_STEP_RST    = 8'd10;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SHORT   = 3'd1,
    EV_LONG    = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_e;

  typedef struct packed {
    logic key_level;
    logic session_start;
    logic timed;
  } req_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] current_state;
  } rsp_t;

endpackage

// ----- rtl/button_click_classifier.sv -----
// Button click classifier top level: request register, one pass of
// state machine and counter logic, result register. Uses bcc_pkg.
// Throughput: one request per cycle; the result register and the request
// register stall together when the result is not taken.
// Reset: asynchronous, active low; state idle, counters zero, registers
// at their default values.
module button_click_classifier #(
  parameter int unsigned TIME_WIDTH = bcc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bcc_pkg::req_t                       in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bcc_pkg::rsp_t                       out_rsp_o
);
  import bcc_pkg::*;

  localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_SHORT    = 3'd3,
    ST_LONG     = 3'd4,
    ST_DOUBLE   = 3'd5,
    ST_WAIT     = 3'd6
  } state_e;

  // Configuration registers
  logic [CFG_W-1:0]  dbl_gap_q, long_time_q, min_time_q, stuck_time_q, confirm_time_q;
  logic [STEP_W-1:0] scan_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_gap_q      <= DOUBLE_GAP_RST;
      long_time_q    <= LONG_TIME_RST;
      min_time_q     <= MIN_TIME_RST;
      stuck_time_q   <= STUCK_TIME_RST;
      confirm_time_q <= CONFIRM_TIME_RST;
      scan_step_q    <= SCAN_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DOUBLE_GAP:   dbl_gap_q      <= cfg_data_i;
        CFG_LONG_TIME:    long_time_q    <= cfg_data_i;
        CFG_MIN_TIME:     min_time_q     <= cfg_data_i;
        CFG_STUCK_TIME:   stuck_time_q   <= cfg_data_i;
        CFG_CONFIRM_TIME: confirm_time_q <= cfg_data_i;
        CFG_SCAN_STEP:    scan_step_q    <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Request register and flow control
  logic in_valid_q;
  req_t req_q;
  logic advance, proc;

  assign advance    = !out_valid_o || out_ready_i;
  assign proc       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // Classifier state
  state_e                state_q, state_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [TIME_WIDTH-1:0] since_press_q, since_press_d;
  logic [TIME_WIDTH-1:0] since_rel_q, since_rel_d;
  logic [TIME_WIDTH-1:0] held_q, held_d;
  logic                  timed_q, timed_d;
  event_e                ev_d;

  function automatic logic [TIME_WIDTH-1:0] sat_add(logic [TIME_WIDTH-1:0] a,
                                                    logic [STEP_W-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + (TIME_WIDTH+1)'(b);
    return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
  endfunction

  logic pressed;
  logic [CMP_W-1:0] sp_c, sr_c, held_c, el_c;
  logic [CMP_W-1:0] dbl_c, long_c, min_c, stuck_c, conf_c;

  always_comb begin
    pressed = !req_q.key_level;
    // session start clears the counters before time advances
    elapsed_d     = sat_add(req_q.session_start ? '0 : elapsed_q, scan_step_q);
    since_press_d = sat_add(req_q.session_start ? '0 : since_press_q, scan_step_q);
    since_rel_d   = sat_add(req_q.session_start ? '0 : since_rel_q, scan_step_q);
    held_d        = req_q.session_start ? '0 : held_q;
    timed_d       = req_q.session_start ? req_q.timed : timed_q;
    state_d       = state_q;
    ev_d          = EV_NONE;

    sp_c    = CMP_W'(since_press_d);
    sr_c    = CMP_W'(since_rel_d);
    held_c  = CMP_W'(held_d);
    el_c    = CMP_W'(elapsed_d);
    dbl_c   = CMP_W'(dbl_gap_q);
    long_c  = CMP_W'(long_time_q);
    min_c   = CMP_W'(min_time_q);
    stuck_c = CMP_W'(stuck_time_q);
    conf_c  = CMP_W'(confirm_time_q);

    unique case (state_q)
      ST_IDLE: begin
        if (timed_d && el_c > conf_c) begin
          ev_d    = EV_TIMEOUT;
          timed_d = 1'b0;
        end else if (pressed) begin
          state_d       = ST_PRESSED;
          since_press_d = '0;
        end
      end
      ST_PRESSED: begin
        if (!pressed) begin
          held_d      = since_press_d;
          since_rel_d = '0;
          state_d     = ST_RELEASED;
        end else if (sp_c > long_c) begin
          state_d = ST_LONG;
        end else if (sp_c > stuck_c) begin
          state_d = ST_IDLE;
        end
      end
      ST_RELEASED: begin
        if (pressed && sr_c < dbl_c) begin
          state_d = ST_DOUBLE;
        end else if (held_c > min_c && sr_c > dbl_c) begin
          state_d = ST_SHORT;
        end else if (sr_c > stuck_c) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHORT: begin
        ev_d    = EV_SHORT;
        state_d = ST_WAIT;
      end
      ST_LONG: begin
        ev_d    = EV_LONG;
        state_d = ST_WAIT;
      end
      ST_DOUBLE: begin
        ev_d    = EV_DOUBLE;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!pressed) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      elapsed_q     <= '0;
      since_press_q <= '0;
      since_rel_q   <= '0;
      held_q        <= '0;
      timed_q       <= 1'b0;
      out_valid_o   <= 1'b0;
    end else begin
      if (proc) begin
        state_q       <= state_d;
        elapsed_q     <= elapsed_d;
        since_press_q <= since_press_d;
        since_rel_q   <= since_rel_d;
        held_q        <= held_d;
        timed_q       <= timed_d;
      end
      if (advance) out_valid_o <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_rsp_o.event_res     <= ev_d;
      out_rsp_o.current_state <= state_d;
    end
  end

  // Checks
  a_short_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.event_res == EV_SHORT |-> out_rsp_o.current_state == ST_WAIT)
    else $error("short event without wait state");

  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.event_res == EV_TIMEOUT |-> out_rsp_o.current_state == ST_IDLE)
    else $error("timeout event outside idle");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && in_valid_q)
    else $error("request stalled with empty result register");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result appeared without a request");

  a_timed_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && ev_d == EV_TIMEOUT |=> !timed_q)
    else $error("timed session kept after timeout event");

endmodule
